[src/mfa_pkg.sv]
// Shared constants and types for the mixed fraction ALU.
// No dependencies.
package mfa_pkg;

  localparam int unsigned PartWidthDef = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned WholeW = 48;
  localparam int unsigned FracW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_NEG = 3'd4,
    KIND_CMP = 3'd5
  } kind_t;

  // control word carried alongside the data from the third front stage through the divider
  typedef struct packed {
    logic        fault;
    logic        is_cmp;
    logic        neg;
    logic        cmp_less;
    logic        cmp_equal;
  } mfa_ctl_t;

endpackage

[src/mixed_fraction_alu_unit.sv]
// Mixed fraction ALU: add, subtract, multiply, divide, negate, compare.
// One request on the in_ channel gives one result on the out_ channel.
// Requests are accepted when in_valid is high and in_stall low; results
// leave when out_valid is high and out_stall low.
// Pipeline: 3 front stages, 4*PART_WIDTH divider stages, one output register.
// Throughput: one request per cycle while no stall on out_ holds the pipeline;
// the divider is fully pipelined, one quotient bit per stage, and sets the depth.
// A stall on out_ while out_valid is high freezes the whole pipeline;
// in_stall follows it, so nothing is lost or repeated. Reset clears all
// valid bits; payload registers are not reset. A fault (zero denominator,
// zero divisor, unknown op, result too wide) zeroes every field but fault.
// Depends on mfa_pkg, mfa_front, mfa_divider.
module mixed_fraction_alu_unit
  import mfa_pkg::*;
#(
  parameter int unsigned PART_WIDTH = PartWidthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KindW-1:0]      in_kind,
  input  logic                  in_a_negative,
  input  logic [PART_WIDTH-1:0] in_a_whole,
  input  logic [PART_WIDTH-1:0] in_a_num,
  input  logic [PART_WIDTH-1:0] in_a_den,
  input  logic                  in_b_negative,
  input  logic [PART_WIDTH-1:0] in_b_whole,
  input  logic [PART_WIDTH-1:0] in_b_num,
  input  logic [PART_WIDTH-1:0] in_b_den,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_r_negative,
  output logic [WholeW-1:0]     out_r_whole,
  output logic [FracW-1:0]      out_r_num,
  output logic [FracW-1:0]      out_r_den,
  output logic                  out_cmp_less,
  output logic                  out_cmp_equal,
  output logic                  out_fault
);
  localparam int unsigned PW = PART_WIDTH;
  localparam int unsigned NW = 4 * PW;
  localparam int unsigned XW = (NW > WholeW) ? NW : WholeW;

  logic out_valid_r;
  logic adv;
  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  logic            f_v;
  mfa_ctl_t        f_ctl;
  logic [NW-1:0]   f_mag;
  logic [2*PW-1:0] f_den;

  mfa_front #(.PW(PW), .NW(NW)) u_front (
    .clk, .rst_n, .adv,
    .in_v(in_valid), .kind(in_kind),
    .a_neg(in_a_negative), .a_whole(in_a_whole), .a_num(in_a_num), .a_den(in_a_den),
    .b_neg(in_b_negative), .b_whole(in_b_whole), .b_num(in_b_num), .b_den(in_b_den),
    .out_v(f_v), .ctl(f_ctl), .mag(f_mag), .den(f_den)
  );

  logic            d_v;
  mfa_ctl_t        d_ctl;
  logic [NW-1:0]   d_quo;
  logic [2*PW-1:0] d_rem, d_den;

  mfa_divider #(.PW(PW), .NW(NW)) u_div (
    .clk, .rst_n, .adv,
    .in_v(f_v), .in_ctl(f_ctl), .in_mag(f_mag),
    .in_den((f_ctl.is_cmp || f_den == '0) ? (2*PW)'(1) : f_den),
    .out_v(d_v), .out_ctl(d_ctl), .quo(d_quo), .rem(d_rem), .out_den(d_den)
  );

  logic bad, zero_q;
  logic [XW-1:0] q_x;
  logic [XW-1:0] den_x;
  assign q_x = XW'(d_quo);
  assign den_x = XW'(d_den);
  assign zero_q = (d_quo == '0) && (d_rem == '0);
  assign bad = d_ctl.fault || (!d_ctl.is_cmp &&
               (d_den == '0 || (den_x >> FracW) != '0 || (q_x >> WholeW) != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fault      <= bad;
      out_cmp_less   <= !bad && d_ctl.is_cmp && d_ctl.cmp_less;
      out_cmp_equal  <= !bad && d_ctl.is_cmp && d_ctl.cmp_equal;
      out_r_negative <= !bad && !d_ctl.is_cmp && d_ctl.neg && !zero_q;
      out_r_whole    <= (bad || d_ctl.is_cmp) ? '0 : WholeW'(q_x);
      out_r_num      <= (bad || d_ctl.is_cmp) ? '0 : FracW'(XW'(d_rem));
      out_r_den      <= (bad || d_ctl.is_cmp) ? '0 : FracW'(den_x);
    end
  end

  assign out_valid = out_valid_r;

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> !out_r_negative && out_r_den == '0 && !out_cmp_less)
    else $error("fault result carries data");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fault && out_r_den != '0 |-> out_r_num < out_r_den)
    else $error("remainder not below denominator");
  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_cmp_less && out_cmp_equal))
    else $error("compare less and equal both set");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r_whole))
    else $error("stalled result changed");
endmodule

[src/mfa_front.sv]
// Front stages: improper numerators, products, sign and magnitude, compare.
// Depends on mfa_pkg.
module mfa_front
  import mfa_pkg::*;
#(
  parameter int unsigned PW = PartWidthDef,
  parameter int unsigned NW = 4 * PW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  logic [KindW-1:0] kind,
  input  logic            a_neg,
  input  logic [PW-1:0]   a_whole,
  input  logic [PW-1:0]   a_num,
  input  logic [PW-1:0]   a_den,
  input  logic            b_neg,
  input  logic [PW-1:0]   b_whole,
  input  logic [PW-1:0]   b_num,
  input  logic [PW-1:0]   b_den,
  output logic            out_v,
  output mfa_ctl_t        ctl,
  output logic [NW-1:0]   mag,
  output logic [2*PW-1:0] den
);
  localparam int unsigned IW = 2 * PW + 1;

  // stage 1: improper numerators
  logic           v1_r;
  logic [KindW-1:0] k1_r;
  logic           sa1_r, sb1_r, bad1_r;
  logic [IW-1:0]  ia1_r, ib1_r;
  logic [PW-1:0]  da1_r, db1_r;

  // stage 2: products
  logic           v2_r;
  logic [KindW-1:0] k2_r;
  logic           sa2_r, sb2_r, bad2_r;
  logic [NW-1:0]  p2_r, q2_r;
  logic [2*PW-1:0] d2_r;

  logic [NW-1:0]  p_nxt, q_nxt;
  logic [2*PW-1:0] d_nxt;
  logic           bad_nxt;
  logic [NW-1:0]  dq_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      out_v <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r  <= kind;
      sa1_r <= a_neg;
      sb1_r <= b_neg;
      ia1_r <= IW'(a_whole) * IW'(a_den) + IW'(a_num);
      ib1_r <= IW'(b_whole) * IW'(b_den) + IW'(b_num);
      da1_r <= a_den;
      db1_r <= b_den;
      bad1_r <= (kind > KIND_CMP) || (a_den == '0) ||
                (kind != KIND_NEG && b_den == '0);
    end
  end

  always_comb begin
    p_nxt = NW'(ia1_r) * NW'(db1_r);
    q_nxt = NW'(ib1_r) * NW'(da1_r);
    d_nxt = da1_r * db1_r;
    dq_prod = NW'(da1_r) * NW'(ib1_r);
    bad_nxt = bad1_r;
    case (k1_r)
      KIND_MUL: begin
        p_nxt = NW'(ia1_r) * NW'(ib1_r);
      end
      KIND_DIV: begin
        d_nxt = (2*PW)'(dq_prod);
        bad_nxt = bad1_r || (ib1_r == '0) || ((dq_prod >> FracW) != '0);
      end
      KIND_NEG: begin
        p_nxt = NW'(ia1_r);
        d_nxt = (2*PW)'(da1_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_r <= k1_r;
      sa2_r <= (k1_r == KIND_NEG) ? !sa1_r : sa1_r;
      sb2_r <= (k1_r == KIND_SUB) ? !sb1_r : sb1_r;
      p2_r <= p_nxt;
      q2_r <= q_nxt;
      d2_r <= d_nxt;
      bad2_r <= bad_nxt;
    end
  end

  // stage 3: sign and magnitude, compare
  logic ge;
  logic sa_c, sb_c;
  mfa_ctl_t ctl_nxt;
  logic [NW-1:0] mag_nxt;
  always_comb begin
    ge = p2_r >= q2_r;
    sa_c = sa2_r && p2_r != '0;
    sb_c = sb2_r && q2_r != '0;
    ctl_nxt = '0;
    ctl_nxt.fault = bad2_r;
    mag_nxt = p2_r;
    case (k2_r)
      KIND_ADD, KIND_SUB: begin
        if (sa2_r == sb2_r) begin
          mag_nxt = p2_r + q2_r;
          ctl_nxt.neg = sa2_r;
        end else if (ge) begin
          mag_nxt = p2_r - q2_r;
          ctl_nxt.neg = sa2_r;
        end else begin
          mag_nxt = q2_r - p2_r;
          ctl_nxt.neg = sb2_r;
        end
      end
      KIND_MUL, KIND_DIV: ctl_nxt.neg = sa2_r ^ sb2_r;
      KIND_NEG: ctl_nxt.neg = sa2_r;
      KIND_CMP: begin
        ctl_nxt.is_cmp = 1'b1;
        if (sa_c != sb_c) begin
          ctl_nxt.cmp_less = sa_c;
        end else begin
          ctl_nxt.cmp_equal = p2_r == q2_r;
          ctl_nxt.cmp_less = sa_c ? (p2_r > q2_r) : !ge;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl <= ctl_nxt;
      mag <= mag_nxt;
      den <= d2_r;
    end
  end
endmodule

[src/mfa_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mfa_pkg.
module mfa_divider
  import mfa_pkg::*;
#(
  parameter int unsigned PW = PartWidthDef,
  parameter int unsigned NW = 4 * PW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  mfa_ctl_t        in_ctl,
  input  logic [NW-1:0]   in_mag,
  input  logic [2*PW-1:0] in_den,
  output logic            out_v,
  output mfa_ctl_t        out_ctl,
  output logic [NW-1:0]   quo,
  output logic [2*PW-1:0] rem,
  output logic [2*PW-1:0] out_den
);
  localparam int unsigned RW = 2 * PW + 1;

  logic            v_r   [NW+1];
  mfa_ctl_t        c_r   [NW+1];
  logic [NW-1:0]   n_r   [NW+1];
  logic [RW-1:0]   r_r   [NW+1];
  logic [2*PW-1:0] d_r   [NW+1];

  always_comb begin
    v_r[0] = in_v;
    c_r[0] = in_ctl;
    n_r[0] = in_mag;
    r_r[0] = '0;
    d_r[0] = in_den;
  end

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [RW-1:0] sh;
    logic          take;
    assign sh = {r_r[i][RW-2:0], n_r[i][NW-1]};
    assign take = sh >= RW'(d_r[i]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[i+1] <= c_r[i];
        d_r[i+1] <= d_r[i];
        r_r[i+1] <= take ? sh - RW'(d_r[i]) : sh;
        n_r[i+1] <= {n_r[i][NW-2:0], take};
      end
    end
  end

  assign out_v   = v_r[NW];
  assign out_ctl = c_r[NW];
  assign quo     = n_r[NW];
  assign rem     = r_r[NW][2*PW-1:0];
  assign out_den = d_r[NW];
endmodule
